[sv/fpa_pkg.sv]
`default_nettype none
package fpa_pkg;

  // Operation codes carried in in_tuser
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_LT   = 4'd4,
    OP_GT   = 4'd5,
    OP_LE   = 4'd6,
    OP_GE   = 4'd7,
    OP_EQ   = 4'd8,
    OP_NE   = 4'd9,
    OP_MIN  = 4'd10,
    OP_MAX  = 4'd11,
    OP_INCR = 4'd12
  } op_t;

  localparam int FIELD_W = 32;
  localparam int WIDE_W  = 64;

  typedef logic signed [FIELD_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

endpackage
`default_nettype wire

[sv/fpa_mul.sv]
`default_nettype none
module fpa_mul import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic  clk,
  input  wire logic  en,
  input  wire word_t a,
  input  wire word_t b,
  output wide_t      prod_rnd
);

  localparam logic [WIDE_W-1:0] HALF = (WIDE_W'(1) << FRAC_BITS) >> 1;

  wide_t             prod_r;
  logic [WIDE_W-1:0] mag_r;
  logic              neg_r;
  wide_t             res_r;

  // three stages: product, rounded magnitude, signed result
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= WIDE_W'(a) * WIDE_W'(b);
      mag_r  <= ((prod_r < 0 ? WIDE_W'(-prod_r) : WIDE_W'(prod_r)) + HALF) >> FRAC_BITS;
      neg_r  <= prod_r < 0;
      res_r  <= neg_r ? -wide_t'(mag_r) : wide_t'(mag_r);
    end
  end

  assign prod_rnd = res_r;

endmodule
`default_nettype wire

[sv/fpa_div.sv]
`default_nettype none
module fpa_div import fpa_pkg::*; #(
  parameter int NB = 40
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [NB-1:0]     num,
  input  wire logic [FIELD_W-1:0] den,
  output logic [NB-1:0]          quo,
  output logic [FIELD_W-1:0]     rem,
  output logic [FIELD_W-1:0]     den_out
);

  logic [NB-1:0]      num_r [NB];
  logic [NB-1:0]      quo_r [NB];
  logic [FIELD_W-1:0] rem_r [NB];
  logic [FIELD_W-1:0] den_r [NB];

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [NB-1:0]      n_in;
    logic [NB-1:0]      q_in;
    logic [FIELD_W-1:0] r_in;
    logic [FIELD_W-1:0] d_in;
    logic [FIELD_W:0]   trial;
    logic               fits;

    if (k == 0) begin : g_first
      assign n_in = num;
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign n_in = num_r[k-1];
      assign q_in = quo_r[k-1];
      assign r_in = rem_r[k-1];
      assign d_in = den_r[k-1];
    end

    assign trial = {r_in, n_in[NB-1]};
    assign fits  = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= n_in << 1;
        quo_r[k] <= {q_in[NB-2:0], fits};
        rem_r[k] <= fits ? FIELD_W'(trial - {1'b0, d_in}) : FIELD_W'(trial);
        den_r[k] <= d_in;
      end
    end
  end

  assign quo     = quo_r[NB-1];
  assign rem     = rem_r[NB-1];
  assign den_out = den_r[NB-1];

endmodule
`default_nettype wire

[sv/fixed_point_alu.sv]
`default_nettype none
// Channel | Ports     | Word layout (lowest bit first)
// input   | in_*      | tdata: operand_a[31:0], operand_b[63:32]; tuser: opcode[3:0]
// result  | out_*     | tdata: result_value[31:0], compare_true, saturated,
//         |           |        divide_by_zero, zero pad to 40 bits
//
// One word enters per cycle while the output is not stalled; the pipeline depth
// is set by the divider, which resolves one quotient bit per stage.
// All other operations ride delay lines of the same length.
// rst_n is synchronous, active low, and clears only the valid bits.
// The whole pipeline advances whenever the output register is empty or being
// drained, so a stall freezes every stage and nothing is lost or repeated.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // operand_a, operand_b
  input  wire logic [3:0]  in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // result_value, compare_true, saturated, divide_by_zero
);

  localparam int EFF_BITS = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;
  localparam int SH       = FIELD_W - EFF_BITS;
  localparam int NB       = FIELD_W + FRAC_BITS;
  localparam int MUL_LAT  = 3;
  localparam wide_t HI    = (wide_t'(1) <<< (EFF_BITS - 1)) - wide_t'(1);
  localparam wide_t LO    = -HI - wide_t'(1);

  logic en;

  // Input stage: narrow the operands to the word width
  logic  s0_v_r;
  op_t   s0_op_r;
  word_t s0_a_r;
  word_t s0_b_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_op_r <= op_t'(in_tuser);
      s0_a_r  <= word_t'(in_tdata[31:0] << SH) >>> SH;
      s0_b_r  <= word_t'(in_tdata[63:32] << SH) >>> SH;
    end
  end

  // Simple operations: add, subtract, compare, min, max, increment
  wide_t simple_wide;
  logic  simple_cmp;
  logic  a_lt_b;
  logic  a_eq_b;

  assign a_lt_b = s0_a_r < s0_b_r;
  assign a_eq_b = s0_a_r == s0_b_r;

  always_comb begin
    simple_wide = '0;
    simple_cmp  = 1'b0;
    case (s0_op_r)
      OP_ADD:  simple_wide = WIDE_W'(s0_a_r) + WIDE_W'(s0_b_r);
      OP_SUB:  simple_wide = WIDE_W'(s0_a_r) - WIDE_W'(s0_b_r);
      OP_INCR: simple_wide = WIDE_W'(s0_a_r) + wide_t'(1);
      OP_MIN:  simple_wide = a_lt_b ? WIDE_W'(s0_a_r) : WIDE_W'(s0_b_r);
      OP_MAX:  simple_wide = (!a_lt_b && !a_eq_b) ? WIDE_W'(s0_a_r) : WIDE_W'(s0_b_r);
      OP_LT:   simple_cmp  = a_lt_b;
      OP_GT:   simple_cmp  = !a_lt_b && !a_eq_b;
      OP_LE:   simple_cmp  = a_lt_b || a_eq_b;
      OP_GE:   simple_cmp  = !a_lt_b;
      OP_EQ:   simple_cmp  = a_eq_b;
      OP_NE:   simple_cmp  = !a_eq_b;
      default: begin
      end
    endcase
  end

  // Multiplier
  wide_t mul_out;

  fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk      (clk),
    .en       (en),
    .a        (s0_a_r),
    .b        (s0_b_r),
    .prod_rnd (mul_out)
  );

  // Divider on magnitudes
  logic [FIELD_W-1:0] mag_a;
  logic [FIELD_W-1:0] mag_b;
  logic [NB-1:0]      div_num;
  logic [NB-1:0]      div_quo;
  logic [FIELD_W-1:0] div_rem;
  logic [FIELD_W-1:0] div_den;

  assign mag_a   = s0_a_r < 0 ? FIELD_W'(-s0_a_r) : FIELD_W'(s0_a_r);
  assign mag_b   = s0_b_r < 0 ? FIELD_W'(-s0_b_r) : FIELD_W'(s0_b_r);
  assign div_num = NB'(mag_a) << FRAC_BITS;

  fpa_div #(.NB(NB)) u_div (
    .clk     (clk),
    .en      (en),
    .num     (div_num),
    .den     (mag_b),
    .quo     (div_quo),
    .rem     (div_rem),
    .den_out (div_den)
  );

  // Delay lines matching the divider depth
  logic  line_v_r    [NB];
  op_t   line_op_r   [NB];
  logic  line_dz_r   [NB];
  logic  line_neg_r  [NB];
  wide_t line_wide_r [NB];
  logic  line_cmp_r  [NB];
  wide_t mul_line_r  [NB-MUL_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) begin
        line_v_r[i] <= 1'b0;
      end
    end else if (en) begin
      line_v_r[0] <= s0_v_r;
      for (int i = 1; i < NB; i++) begin
        line_v_r[i] <= line_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_op_r[0]   <= s0_op_r;
      line_dz_r[0]   <= s0_b_r == '0;
      line_neg_r[0]  <= (s0_a_r < 0) != (s0_b_r < 0);
      line_wide_r[0] <= simple_wide;
      line_cmp_r[0]  <= simple_cmp;
      for (int i = 1; i < NB; i++) begin
        line_op_r[i]   <= line_op_r[i-1];
        line_dz_r[i]   <= line_dz_r[i-1];
        line_neg_r[i]  <= line_neg_r[i-1];
        line_wide_r[i] <= line_wide_r[i-1];
        line_cmp_r[i]  <= line_cmp_r[i-1];
      end
      mul_line_r[0] <= mul_out;
      for (int i = 1; i < NB - MUL_LAT; i++) begin
        mul_line_r[i] <= mul_line_r[i-1];
      end
    end
  end

  // Merge stage: round the quotient and pick the wide value
  logic              round_up;
  logic [WIDE_W-1:0] quo_rnd;
  wide_t             merge_wide;
  logic              dz_hit;

  logic  m_v_r;
  logic  m_cmp_r;
  logic  m_dz_r;
  wide_t m_wide_r;

  assign round_up = {div_rem, 1'b0} >= {1'b0, div_den};
  assign quo_rnd  = WIDE_W'(div_quo) + WIDE_W'(round_up);
  assign dz_hit   = (line_op_r[NB-1] == OP_DIV) && line_dz_r[NB-1];

  always_comb begin
    case (line_op_r[NB-1])
      OP_MUL:  merge_wide = mul_line_r[NB-MUL_LAT-1];
      OP_DIV:  merge_wide = dz_hit ? wide_t'(0)
                          : (line_neg_r[NB-1] ? -wide_t'(quo_rnd) : wide_t'(quo_rnd));
      default: merge_wide = line_wide_r[NB-1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= line_v_r[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_wide_r <= merge_wide;
      m_cmp_r  <= line_cmp_r[NB-1];
      m_dz_r   <= dz_hit;
    end
  end

  // Output register: clamp to the word range
  logic  out_v_r;
  word_t out_val_r;
  logic  out_cmp_r;
  logic  out_sat_r;
  logic  out_dz_r;
  logic  over_hi;
  logic  under_lo;

  assign over_hi  = m_wide_r > HI;
  assign under_lo = m_wide_r < LO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r <= over_hi ? FIELD_W'(HI) : (under_lo ? FIELD_W'(LO) : FIELD_W'(m_wide_r));
      out_sat_r <= over_hi || under_lo;
      out_cmp_r <= m_cmp_r;
      out_dz_r  <= m_dz_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_dz_r, out_sat_r, out_cmp_r, out_val_r};

endmodule
`default_nettype wire
